@@ rtl/ovn_pkg.sv @@
// ----------------------------------------------------------------------------
// Octave value noise package
// Shared constants for the octave value noise block.
// ----------------------------------------------------------------------------
package ovn_pkg;

  localparam int unsigned MaxDepthDefault  = 16;
  localparam int unsigned CoordBitsDefault = 12;

  localparam logic [31:0] HashMulA = 32'd15731;
  localparam logic [31:0] HashAddA = 32'd789221;
  localparam logic [31:0] HashAddB = 32'd1376312589;
  localparam logic [31:0] HashMulB = 32'd543;

  // Register indexes on the configuration port.
  localparam logic [1:0] RegWidth  = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegStart  = 2'd2;
  localparam logic [1:0] RegEnd    = 2'd3;

  // Shared unit operations.
  localparam logic [2:0] OpMul = 3'd0;
  localparam logic [2:0] OpAdd = 3'd1;
  localparam logic [2:0] OpXor = 3'd2;

endpackage

@@ rtl/ovn_divider.sv @@
// ----------------------------------------------------------------------------
// Octave value noise divider
// Restoring divider, one quotient bit per cycle, for cell and weight terms.
// ----------------------------------------------------------------------------
module ovn_divider import ovn_pkg::*; #(
  parameter int unsigned NumBits = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [NumBits-1:0] dividend_i,
  input  logic [12:0]        divisor_i,
  output logic               done_o,
  output logic [NumBits-1:0] quot_o,
  output logic [12:0]        rem_o
);

  localparam int unsigned CntBits = $clog2(NumBits + 1);

  logic [NumBits-1:0] quot_q, quot_d;
  logic [13:0]        rem_q, rem_d;
  logic [12:0]        div_q, div_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [13:0]        trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[12:0], quot_q[NumBits-1]};
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
      cnt_d  = CntBits'(NumBits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quot_d = {quot_q[NumBits-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        rem_d     = trial - {1'b0, div_q};
        quot_d[0] = 1'b1;
      end else begin
        rem_d = trial;
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q[12:0];

endmodule

@@ rtl/ovn_alu.sv @@
// ----------------------------------------------------------------------------
// Octave value noise arithmetic unit
// Shared 32-bit wrapping multiply, add and exclusive-or with a result register.
// ----------------------------------------------------------------------------
module ovn_alu import ovn_pkg::*; (
  input  logic        clk_i,
  input  logic [2:0]  op_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] res_o
);

  logic [31:0] res_d, res_q;

  always_comb begin
    case (op_i)
      OpMul:   res_d = a_i * b_i;
      OpAdd:   res_d = a_i + b_i;
      OpXor:   res_d = a_i ^ b_i;
      default: res_d = a_i;
    endcase
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

@@ rtl/octave_value_noise_2d.sv @@
// ----------------------------------------------------------------------------
// Octave value noise 2D
// Sums several octaves of hashed lattice value noise and returns the magnitude.
// ----------------------------------------------------------------------------
// Usage: configure surface sizes and the octave range over the APB port while
// the block is idle. Pulse start with x_pos_i, y_pos_i and time_quarters_i
// while busy is low; the item is taken on that edge and busy rises. The
// result appears on noise_magnitude_o for exactly one cycle with done_o high,
// after which busy falls. The receiver cannot stall.
// The next item can be taken in the cycle after done_o. Each octave runs four
// bit-serial divisions, four corner hashes run step by step on the shared
// 32-bit unit, the blend products (one 34x34 signed product per cycle) and
// octave control. An empty octave range gives 0.
// Reset restores the default register values and returns the block to idle.
// ----------------------------------------------------------------------------
module octave_value_noise_2d import ovn_pkg::*; #(
  parameter int unsigned MaxDepth  = MaxDepthDefault,
  parameter int unsigned CoordBits = CoordBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [11:0] x_pos_i,
  input  logic [11:0] y_pos_i,
  input  logic [23:0] time_quarters_i,
  output logic        done_o,
  output logic [31:0] noise_magnitude_o
);

  localparam logic [4:0] MaxDepthL = 5'(MaxDepth);
  localparam logic [11:0] CoordMask = 12'((64'd1 << CoordBits) - 64'd1);

  localparam logic [4:0] SIdle  = 5'd0;
  localparam logic [4:0] SOct   = 5'd1;
  localparam logic [4:0] SDivCx = 5'd2;
  localparam logic [4:0] SDivFx = 5'd3;
  localparam logic [4:0] SDivCy = 5'd4;
  localparam logic [4:0] SDivFy = 5'd5;
  localparam logic [4:0] SHash  = 5'd6;
  localparam logic [4:0] SHWait = 5'd7;
  localparam logic [4:0] SBlend = 5'd8;
  localparam logic [4:0] SAcc   = 5'd9;
  localparam logic [4:0] SDone  = 5'd10;
  localparam logic [4:0] SWait  = 5'd11;

  // Configuration registers.
  logic [12:0] width_q, height_q;
  logic [4:0]  sdepth_q, edepth_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 13'd4096;
      height_q <= 13'd4096;
      sdepth_q <= 5'd0;
      edepth_q <= 5'd8;
    end else if (wr_en) begin
      case (paddr[3:2])
        RegWidth:  width_q  <= pwdata[12:0];
        RegHeight: height_q <= pwdata[12:0];
        RegStart:  sdepth_q <= pwdata[4:0];
        RegEnd:    edepth_q <= pwdata[4:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegWidth:  prdata = {19'd0, width_q};
      RegHeight: prdata = {19'd0, height_q};
      RegStart:  prdata = {27'd0, sdepth_q};
      RegEnd:    prdata = {27'd0, edepth_q};
      default:   prdata = '0;
    endcase
  end

  // Datapath state.
  logic [4:0]  state_q, state_d;
  logic [4:0]  k_q, k_d, stop_q, stop_d;
  logic [11:0] x_q, y_q;
  logic [31:0] seed_q;
  logic [12:0] w_q, h_q;
  logic [31:0] cx_q, cx_d, cy_q, cy_d;
  logic [16:0] fx_q, fx_d, fy_q, fy_d;
  logic [3:0]  hstep_q, hstep_d;
  logic [1:0]  corner_q, corner_d;
  logic [31:0] ha_q, ha_d, ht_q, ht_d;
  logic signed [31:0] hv_q [4];
  logic signed [31:0] hv_d;
  logic        hv_we;
  logic [2:0]  bstep_q, bstep_d;
  logic signed [63:0] top_q, top_d, bot_q, bot_d, v_q, v_d;
  logic signed [63:0] sum_q, sum_d;
  logic [31:0] res_q, res_d;
  logic        done_q, done_d;

  // Divider.
  logic        div_start;
  logic [31:0] div_num;
  logic [12:0] div_den;
  logic        div_done;
  logic [31:0] div_quot;
  logic [12:0] div_rem;

  ovn_divider #(.NumBits(32)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // Shared hash arithmetic.
  logic [2:0]  alu_op;
  logic [31:0] alu_a, alu_b, alu_res;

  ovn_alu u_alu (
    .clk_i (clk_i),
    .op_i  (alu_op),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res)
  );

  logic [31:0] ccx, ccy;
  always_comb begin
    ccx = corner_q[0] ? cx_q - 32'd1 : cx_q;
    ccy = corner_q[1] ? cy_q - 32'd1 : cy_q;
  end

  // Hash sequence: each step issues one ALU op; its result is registered in the ALU and read by the next step.
  always_comb begin
    alu_op = OpAdd;
    alu_a  = '0;
    alu_b  = '0;
    case (hstep_q)
      4'd0: begin alu_op = OpAdd; alu_a = ccx << 13; alu_b = seed_q; end
      4'd1: begin alu_op = OpXor; alu_a = alu_res;   alu_b = ccx;    end
      4'd2: begin alu_op = OpAdd; alu_a = ccy << 17; alu_b = seed_q; end
      4'd3: begin alu_op = OpXor; alu_a = alu_res;   alu_b = ccy;    end
      4'd4: begin alu_op = OpMul; alu_a = ha_q;      alu_b = alu_res; end
      4'd5: begin alu_op = OpMul; alu_a = alu_res;   alu_b = HashMulA; end
      4'd6: begin alu_op = OpAdd; alu_a = alu_res;   alu_b = HashAddA; end
      4'd7: begin alu_op = OpMul; alu_a = alu_res;   alu_b = ha_q;   end
      4'd8: begin alu_op = OpAdd; alu_a = alu_res;   alu_b = HashAddB; end
      4'd9: begin alu_op = OpMul; alu_a = ht_q;      alu_b = HashMulB; end
      4'd10: begin alu_op = OpAdd; alu_a = alu_res;  alu_b = ht_q;   end
      default: ;
    endcase
  end

  // Blend multiplier operands, one product per cycle.
  logic signed [33:0] bm_a;
  logic signed [33:0] bm_b;
  logic signed [67:0] bm_p;
  always_comb begin
    bm_a = '0;
    bm_b = '0;
    case (bstep_q)
      3'd0: begin bm_a = 34'(hv_q[0]); bm_b = {17'd0, fx_q}; end
      3'd1: begin bm_a = 34'(hv_q[1]); bm_b = {17'd0, 17'h10000 - fx_q}; end
      3'd2: begin bm_a = 34'(hv_q[2]); bm_b = {17'd0, fx_q}; end
      3'd3: begin bm_a = 34'(hv_q[3]); bm_b = {17'd0, 17'h10000 - fx_q}; end
      // The row sums are 48 bits wide, so each is weighted as a signed high
      // part and an unsigned low 16 bits.
      3'd4: begin bm_a = 34'(top_q >>> 16); bm_b = {17'd0, fy_q}; end
      3'd5: begin bm_a = {18'd0, top_q[15:0]}; bm_b = {17'd0, fy_q}; end
      3'd6: begin bm_a = 34'(bot_q >>> 16); bm_b = {17'd0, 17'h10000 - fy_q}; end
      3'd7: begin bm_a = {18'd0, bot_q[15:0]}; bm_b = {17'd0, 17'h10000 - fy_q}; end
      default: ;
    endcase
    bm_p = bm_a * bm_b;
  end

  logic [12:0] w_eff, h_eff;
  logic [4:0]  stop_c;
  logic [31:0] sx, sy;
  logic [63:0] biased;
  logic signed [63:0] contrib;
  assign w_eff  = (width_q == 13'd0) ? 13'd1 : width_q;
  assign h_eff  = (height_q == 13'd0) ? 13'd1 : height_q;
  assign stop_c = (edepth_q < MaxDepthL) ? edepth_q : MaxDepthL;
  assign sx = 32'(x_q) << k_q;
  assign sy = 32'(y_q) << k_q;
  assign biased = 64'(v_q) + (64'd1 << 62);
  assign contrib = $signed(biased >> (6'd32 + 6'(k_q))) - $signed(64'd1 << (6'd30 - 6'(k_q)));

  always_comb begin
    state_d  = state_q;
    k_d      = k_q;
    stop_d   = stop_q;
    cx_d     = cx_q;
    cy_d     = cy_q;
    fx_d     = fx_q;
    fy_d     = fy_q;
    hstep_d  = hstep_q;
    corner_d = corner_q;
    ha_d     = ha_q;
    ht_d     = ht_q;
    hv_d     = '0;
    hv_we    = 1'b0;
    bstep_d  = bstep_q;
    top_d    = top_q;
    bot_d    = bot_q;
    v_d      = v_q;
    sum_d    = sum_q;
    res_d    = res_q;
    done_d   = 1'b0;
    div_start = 1'b0;
    div_num  = '0;
    div_den  = w_q;
    case (state_q)
      SIdle: begin
        if (start) begin
          k_d    = sdepth_q;
          stop_d = stop_c;
          sum_d  = '0;
          state_d = SOct;
        end
      end
      SOct: begin
        if (k_q >= stop_q) begin
          state_d = SDone;
        end else begin
          div_start = 1'b1;
          div_num   = sx;
          div_den   = w_q;
          state_d   = SDivCx;
        end
      end
      SDivCx: begin
        if (div_done) begin
          cx_d = div_quot;
          div_start = 1'b1;
          div_num = {3'd0, div_rem, 16'd0};
          div_den = w_q;
          state_d = SDivFx;
        end
      end
      SDivFx: begin
        div_den = w_q;
        if (div_done) begin
          fx_d = div_quot[16:0];
          div_start = 1'b1;
          div_num = sy;
          div_den = h_q;
          state_d = SDivCy;
        end
      end
      SDivCy: begin
        div_den = h_q;
        if (div_done) begin
          cy_d = div_quot;
          div_start = 1'b1;
          div_num = {3'd0, div_rem, 16'd0};
          div_den = h_q;
          state_d = SDivFy;
        end
      end
      SDivFy: begin
        if (div_done) begin
          fy_d = div_quot[16:0];
          corner_d = 2'd0;
          hstep_d = 4'd0;
          state_d = SHash;
        end
      end
      SHash: begin
        // Each step leaves its result in the ALU register for the next one.
        hstep_d = hstep_q + 4'd1;
        if (hstep_q == 4'd2) ha_d = alu_res;
        if (hstep_q == 4'd9) ht_d = alu_res;
        if (hstep_q == 4'd10) state_d = SHWait;
        // Step 9 needs a*b, kept from step 5's input.
        if (hstep_q == 4'd5) ht_d = alu_res;
      end
      SHWait: begin
        hstep_d = 4'd11;
        if (hstep_q == 4'd11) begin
          hv_we = 1'b1;
          hv_d  = $signed(32'h4000_0000 - {1'b0, alu_res[30:0]});
          hstep_d = 4'd0;
          if (corner_q == 2'd3) begin
            bstep_d = 3'd0;
            state_d = SBlend;
          end else begin
            corner_d = corner_q + 2'd1;
            state_d = SHash;
          end
        end
      end
      SBlend: begin
        bstep_d = bstep_q + 3'd1;
        case (bstep_q)
          3'd0: top_d = bm_p[63:0];
          3'd1: top_d = top_q + bm_p[63:0];
          3'd2: bot_d = bm_p[63:0];
          3'd3: bot_d = bot_q + bm_p[63:0];
          3'd4: v_d = {bm_p[47:0], 16'd0};
          3'd5: v_d = v_q + bm_p[63:0];
          3'd6: v_d = v_q + {bm_p[47:0], 16'd0};
          default: begin
            v_d = v_q + bm_p[63:0];
            state_d = SAcc;
          end
        endcase
      end
      SAcc: begin
        sum_d = sum_q + contrib;
        k_d = k_q + 5'd1;
        state_d = SOct;
      end
      SDone: begin
        res_d  = sum_q[63] ? 32'(-sum_q) : sum_q[31:0];
        done_d = 1'b1;
        state_d = SWait;
      end
      SWait: state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      done_q  <= 1'b0;
      hstep_q <= '0;
      bstep_q <= '0;
      corner_q <= '0;
      k_q     <= '0;
      stop_q  <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      hstep_q <= hstep_d;
      bstep_q <= bstep_d;
      corner_q <= corner_d;
      k_q     <= k_d;
      stop_q  <= stop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SIdle && start) begin
      x_q    <= x_pos_i & CoordMask;
      y_q    <= y_pos_i & CoordMask;
      seed_q <= {8'd0, time_quarters_i};
      w_q    <= w_eff;
      h_q    <= h_eff;
    end
    cx_q <= cx_d;
    cy_q <= cy_d;
    fx_q <= fx_d;
    fy_q <= fy_d;
    ha_q <= ha_d;
    ht_q <= ht_d;
    top_q <= top_d;
    bot_q <= bot_d;
    v_q   <= v_d;
    sum_q <= sum_d;
    res_q <= res_d;
    if (hv_we) hv_q[corner_q] <= hv_d;
  end

  assign busy = (state_q != SIdle);
  assign done_o = done_q;
  assign noise_magnitude_o = res_q;

endmodule

@@ bench/octave_value_noise_2d_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Octave value noise 2D testbench
// Walks a table of directed points and register settings, then random points over
// several configurations. Each result is compared against its known table value
// or a predictor that sums the octaves of hashed lattice noise in 64-bit integers.
// ----------------------------------------------------------------------------
module octave_value_noise_2d_tb;
  import ovn_pkg::*;

  localparam int unsigned MaxDepth   = 16;
  localparam int unsigned StallLimit = 40000;

  typedef struct {
    logic [11:0] x;
    logic [11:0] y;
    logic [23:0] t;
    logic [12:0] w;
    logic [12:0] h;
    logic [4:0]  s;
    logic [4:0]  e;
    bit          known;
    logic [31:0] value;
  } point_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        start = 1'b0;
  logic        busy;
  logic [11:0] x_pos_i = '0;
  logic [11:0] y_pos_i = '0;
  logic [23:0] time_quarters_i = '0;
  logic        done_o;
  logic [31:0] noise_magnitude_o;

  logic [12:0] cfg_width = 13'd4096, cfg_height = 13'd4096;
  logic [4:0]  cfg_start = 5'd0, cfg_end = 5'd8;
  logic [31:0] magnitude_q[$];
  int unsigned stall_cycles = 0;
  bit          failed = 1'b0;

  octave_value_noise_2d DUT (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic longint corner_value(logic [23:0] seed, logic [31:0] cx, logic [31:0] cy);
    logic [31:0] a, b, n;
    a = ((cx << 13) + {8'd0, seed}) ^ cx;
    b = ((cy << 17) + {8'd0, seed}) ^ cy;
    n = (a * (b * a * HashMulA + HashAddA) + HashAddB + a * b * HashMulB) & 32'h7fffffff;
    return 64'sd1073741824 - longint'({32'd0, n});
  endfunction

  function automatic logic [31:0] noise_magnitude(logic [11:0] xp, logic [11:0] yp,
                                                  logic [23:0] seed);
    longint unsigned w, h, sx, sy;
    longint fx, fy, top, bot, v, sum;
    logic [31:0] cx, cy;
    int unsigned stop;
    w = (cfg_width == 0) ? 1 : cfg_width;
    h = (cfg_height == 0) ? 1 : cfg_height;
    stop = (cfg_end < MaxDepth) ? cfg_end : MaxDepth;
    sum = 0;
    for (int unsigned k = cfg_start; k < stop; k++) begin
      sx = longint'(xp) << k;
      sy = longint'(yp) << k;
      cx = 32'(sx / w);
      cy = 32'(sy / h);
      fx = ((sx % w) << 16) / w;
      fy = ((sy % h) << 16) / h;
      top = corner_value(seed, cx, cy) * fx + corner_value(seed, cx - 1, cy) * (65536 - fx);
      bot = corner_value(seed, cx, cy - 1) * fx
          + corner_value(seed, cx - 1, cy - 1) * (65536 - fx);
      v = top * fy + bot * (65536 - fy);
      sum += v >>> (32 + k);
    end
    if (sum < 0) sum = -sum;
    return sum[31:0];
  endfunction

  // Results are registered, so the values read here are those of the ending cycle.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (done_o) begin
      if (magnitude_q.size() == 0) begin
        $error("noise_magnitude: result 0x%08h with none expected", noise_magnitude_o);
        failed = 1'b1;
      end else begin
        if (noise_magnitude_o !== magnitude_q[0]) begin
          $error("noise_magnitude: expected 0x%08h, actual 0x%08h",
                 magnitude_q[0], noise_magnitude_o);
          failed = 1'b1;
        end
        void'(magnitude_q.pop_front());
      end
    end
    if (stall_cycles >= StallLimit) begin
      $display("[octave_value_noise_2d] ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    @(negedge clk_i);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = {idx, 2'b00}; pwdata = data;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic drain;
    while (magnitude_q.size() != 0 || busy) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_config(logic [12:0] w, logic [12:0] h, logic [4:0] s, logic [4:0] e);
    drain();
    write_reg(RegWidth, 32'(w));   cfg_width  = w;
    write_reg(RegHeight, 32'(h));  cfg_height = h;
    write_reg(RegStart, 32'(s));   cfg_start  = s;
    write_reg(RegEnd, 32'(e));     cfg_end    = e;
  endtask

  task automatic send_point(logic [11:0] xp, logic [11:0] yp, logic [23:0] seed,
                            bit known, logic [31:0] value);
    int unsigned gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    x_pos_i = xp; y_pos_i = yp; time_quarters_i = seed;
    start = 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    magnitude_q.push_back(known ? value : noise_magnitude(xp, yp, seed));
    @(negedge clk_i);
  endtask

  point_t directed [19] = '{
    '{12'd0, 12'd0, 24'd0, 13'd4096, 13'd4096, 5'd0, 5'd8, 1'b0, 32'd0},
    '{12'd4095, 12'd4095, 24'hffffff, 13'd4096, 13'd4096, 5'd0, 5'd8, 1'b0, 32'd0},
    '{12'd4095, 12'd0, 24'h000001, 13'd4096, 13'd4096, 5'd0, 5'd8, 1'b0, 32'd0},
    '{12'd0, 12'd4095, 24'h800000, 13'd4096, 13'd4096, 5'd0, 5'd8, 1'b0, 32'd0},
    // An empty octave range always yields zero.
    '{12'd1234, 12'd777, 24'h123456, 13'd4096, 13'd4096, 5'd5, 5'd5, 1'b1, 32'd0},
    '{12'd4095, 12'd4095, 24'hffffff, 13'd4096, 13'd4096, 5'd9, 5'd3, 1'b1, 32'd0},
    '{12'd100, 12'd200, 24'h00abcd, 13'd4096, 13'd4096, 5'd16, 5'd31, 1'b1, 32'd0},
    '{12'd100, 12'd200, 24'h00abcd, 13'd4096, 13'd4096, 5'd31, 5'd31, 1'b1, 32'd0},
    // End depth beyond the maximum is clamped.
    '{12'd4095, 12'd4095, 24'hffffff, 13'd4096, 13'd4096, 5'd15, 5'd31, 1'b0, 32'd0},
    '{12'd0, 12'd0, 24'd0, 13'd4096, 13'd4096, 5'd0, 5'd16, 1'b0, 32'd0},
    '{12'd2048, 12'd1024, 24'h55aa55, 13'd4096, 13'd4096, 5'd0, 5'd16, 1'b0, 32'd0},
    // Zero sizes behave as a size of one; oversize values are used as given.
    '{12'd4095, 12'd17, 24'h0f0f0f, 13'd0, 13'd0, 5'd0, 5'd4, 1'b0, 32'd0},
    '{12'd3, 12'd4095, 24'hf0f0f0, 13'd1, 13'd1, 5'd2, 5'd6, 1'b0, 32'd0},
    '{12'd4095, 12'd4095, 24'hffffff, 13'd8191, 13'd8191, 5'd0, 5'd16, 1'b0, 32'd0},
    '{12'd1, 12'd1, 24'd0, 13'd8191, 13'd1, 5'd0, 5'd3, 1'b0, 32'd0},
    '{12'd4094, 12'd2, 24'h7fffff, 13'd4097, 13'd3, 5'd1, 5'd2, 1'b0, 32'd0},
    '{12'd0, 12'd0, 24'hffffff, 13'd1, 13'd4096, 5'd0, 5'd1, 1'b0, 32'd0},
    '{12'd2730, 12'd1365, 24'h2aaaaa, 13'd1, 13'd8191, 5'd15, 5'd16, 1'b0, 32'd0},
    '{12'd1365, 12'd2730, 24'h555555, 13'd4096, 13'd4096, 5'd0, 5'd8, 1'b0, 32'd0}
  };

  initial begin
    logic [12:0] w, h;
    logic [4:0]  s, e;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed[i]) begin
      if (directed[i].w != cfg_width || directed[i].h != cfg_height ||
          directed[i].s != cfg_start || directed[i].e != cfg_end) begin
        start = 1'b0;
        set_config(directed[i].w, directed[i].h, directed[i].s, directed[i].e);
      end
      send_point(directed[i].x, directed[i].y, directed[i].t,
                 directed[i].known, directed[i].value);
    end

    for (int phase = 0; phase < 8; phase++) begin
      start = 1'b0;
      case ($urandom_range(0, 3))
        0: w = 13'd4096;
        1: w = 13'($urandom_range(1, 64));
        2: w = 13'($urandom_range(0, 8191));
        default: w = 13'($urandom_range(1, 4096));
      endcase
      h = (phase == 0) ? 13'd8191 : 13'($urandom_range(0, 8191));
      s = 5'($urandom_range(0, 12));
      e = (phase == 7) ? 5'd31 : 5'(s + $urandom_range(0, 4));
      if (phase == 6) begin
        s = 5'd0; e = 5'd16;
      end
      set_config(w, h, s, e);
      for (int n = 0; n < ((phase == 6) ? 60 : 250); n++)
        send_point(12'($urandom), 12'($urandom), 24'($urandom), 1'b0, '0);
    end
    start = 1'b0;

    drain();
    repeat (50) @(posedge clk_i);
    if (!failed) begin
      $display("[octave_value_noise_2d] OK");
    end else begin
      $display("[octave_value_noise_2d] ERROR");
    end
    $finish;
  end

endmodule
